### sv/mmbm_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the memory-mapped bus mapper.
// No dependencies; every other file of the block imports this package.
package mmbm_pkg;

  // Command codes.
  localparam logic [2:0] CMD_PLUG    = 3'd0;
  localparam logic [2:0] CMD_FORCED  = 3'd1;
  localparam logic [2:0] CMD_REMAP   = 3'd2;
  localparam logic [2:0] CMD_UNPLUG  = 3'd3;
  localparam logic [2:0] CMD_READ8   = 3'd4;
  localparam logic [2:0] CMD_READ16  = 3'd5;
  localparam logic [2:0] CMD_WRITE8  = 3'd6;
  localparam logic [2:0] CMD_WRITE16 = 3'd7;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ADDR  = 2'd1;
  localparam logic [1:0] ST_PARAM = 2'd2;

  // Value that an unmapped byte reads as.
  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

  // One request item.
  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  component_id;
    logic [2:0]  memory_id;
    logic [16:0] memory_size;
    logic [15:0] range_start;
    logic [15:0] range_end;
    logic [15:0] mem_offset;
    logic [15:0] address;
    logic [15:0] write_data;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] read_data;
  } resp_t;

  // One entry of the address map.
  typedef struct packed {
    logic        mapped;
    logic [2:0]  mem;
    logic [15:0] idx;
  } map_entry_t;

  // Access to the address map memory.
  typedef struct packed {
    logic        re;
    logic [15:0] raddr;
    logic        we;
    logic [15:0] waddr;
    map_entry_t  wdata;
  } map_req_t;

  // Access to the backing store; wall clears every lane of a row.
  typedef struct packed {
    logic        re;
    logic [15:0] raddr;
    logic        we;
    logic        wall;
    logic [15:0] waddr;
    logic [2:0]  wlane;
    logic [7:0]  wdata;
  } bk_req_t;

endpackage

### sv/mmbm_map_table.sv
`timescale 1ns / 1ps
// Address map memory: one entry per bus address, one read and one write port.
// Depends on mmbm_pkg for the entry and access types.
module mmbm_map_table
  import mmbm_pkg::*;
#(
  parameter int ADDRESS_SPACE = 65536
) (
  input  logic       clk,
  input  map_req_t   req,
  output map_entry_t rdata
);

  localparam int AW = $clog2(ADDRESS_SPACE);

  map_entry_t entries [ADDRESS_SPACE];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (req.we) begin
      entries[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= entries[req.raddr[AW-1:0]];
    end
  end

endmodule

### sv/mmbm_backing.sv
`timescale 1ns / 1ps
// Backing store: one row per byte index, one byte lane per component memory.
// Depends on mmbm_pkg for the access type.
module mmbm_backing
  import mmbm_pkg::*;
#(
  parameter int NUM_MEMORIES    = 8,
  parameter int MAX_MEMORY_SIZE = 65536
) (
  input  logic                          clk,
  input  bk_req_t                       req,
  output logic [NUM_MEMORIES-1:0][7:0]  rdata
);

  localparam int BW = (MAX_MEMORY_SIZE > 1) ? $clog2(MAX_MEMORY_SIZE) : 1;

  logic [NUM_MEMORIES-1:0][7:0] rows [MAX_MEMORY_SIZE];

  // Lane-enabled write; a clear write zeroes the whole row.
  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_MEMORIES; l++) begin
      if (req.we && (req.wall || req.wlane == 3'(l))) begin
        rows[req.waddr[BW-1:0]][l] <= req.wall ? 8'h00 : req.wdata;
      end
    end
    if (req.re) begin
      rdata <= rows[req.raddr[BW-1:0]];
    end
  end

endmodule

### sv/mmbm_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: range checks, map walks, lookups and the result register.
// Depends on mmbm_pkg; drives the map table and backing store ports.
module mmbm_ctrl
  import mmbm_pkg::*;
#(
  parameter int ADDRESS_SPACE   = 65536,
  parameter int NUM_COMPONENTS  = 8,
  parameter int NUM_MEMORIES    = 8,
  parameter int MAX_MEMORY_SIZE = 65536
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clearing,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  req_t                         req_data,
  output logic                         resp_valid,
  input  logic                         resp_stall,
  output resp_t                        resp_data,
  output map_req_t                     map_req,
  input  map_entry_t                   map_rdata,
  output bk_req_t                      bk_req,
  input  logic [NUM_MEMORIES-1:0][7:0] bk_rdata
);

  localparam int CIW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int LW  = (NUM_MEMORIES > 1) ? $clog2(NUM_MEMORIES) : 1;
  localparam logic [3:0]  NCOMP   = 4'(NUM_COMPONENTS);
  localparam logic [3:0]  NMEM    = 4'(NUM_MEMORIES);
  localparam logic [16:0] SPACE   = 17'(ADDRESS_SPACE);
  localparam logic [16:0] LAST    = 17'(ADDRESS_SPACE - 1);
  localparam logic [16:0] MAXSIZE = 17'(MAX_MEMORY_SIZE);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_RCHK   = 4'd3;
  localparam logic [3:0] S_FILL   = 4'd4;
  localparam logic [3:0] S_UNPLUG = 4'd5;
  localparam logic [3:0] S_LK_B   = 4'd6;
  localparam logic [3:0] S_LK_C   = 4'd7;
  localparam logic [3:0] S_LK_D   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]    state;
  req_t          item;
  resp_t         res;
  logic [15:0]   ptr;
  logic [15:0]   walk_s;
  logic [15:0]   walk_e;
  logic [15:0]   off_eff;
  logic [15:0]   fill_idx;
  logic          rd_pend;
  logic          rd_last;
  logic          issued_all;
  logic          ok0_r;
  logic          ok1_r;
  logic [LW-1:0] lane0;
  logic [LW-1:0] lane1;
  logic [7:0]    low_byte;
  logic [15:0]   comp_start [NUM_COMPONENTS];
  logic [15:0]   comp_end   [NUM_COMPONENTS];

  logic           cid_ok;
  logic           mid_ok;
  logic [CIW-1:0] cidx;
  logic           addr_in;
  logic           addr_lt_last;
  logic           is_write;
  logic           is_access;
  logic           ok0;
  logic           ok1;
  logic [15:0]    diff;
  logic [16:0]    span;
  logic [16:0]    size_sat;
  logic           range_bad;
  logic           check_param;
  logic           res_load;

  // A looked-up entry points at a byte only if it is mapped and in bounds.
  function automatic logic entry_ok(input map_entry_t e);
    entry_ok = e.mapped && ({1'b0, e.mem} < NMEM) && ({1'b0, e.idx} < MAXSIZE);
  endfunction

  // Decoded fields of the request being worked on.
  assign cid_ok       = {1'b0, item.component_id} < NCOMP;
  assign mid_ok       = {1'b0, item.memory_id} < NMEM;
  assign cidx         = item.component_id[CIW-1:0];
  assign addr_in      = {1'b0, item.address} < SPACE;
  assign addr_lt_last = {1'b0, item.address} < LAST;
  assign is_write     = (item.command == CMD_WRITE8) || (item.command == CMD_WRITE16);
  assign is_access    = is_write || (item.command == CMD_READ8) ||
                        (item.command == CMD_READ16);
  assign ok0          = addr_in && entry_ok(map_rdata);
  assign ok1          = addr_lt_last && entry_ok(map_rdata);

  // Slot numbers out of range are refused before anything is touched.
  assign check_param = ((item.command == CMD_PLUG || item.command == CMD_FORCED ||
                         item.command == CMD_REMAP) && (!cid_ok || !mid_ok)) ||
                       (item.command == CMD_UNPLUG && !cid_ok);

  // Range check: start above end, end beyond the space, or past the memory.
  assign diff      = walk_e - walk_s;
  assign span      = {1'b0, diff} + {1'b0, off_eff};
  assign size_sat  = (item.memory_size > MAXSIZE) ? MAXSIZE : item.memory_size;
  assign range_bad = (walk_s > walk_e) || ({1'b0, walk_e} >= SPACE) || (span >= size_sat);

  assign req_stall = (state != S_IDLE) || clearing;

  // A finished result moves to the output register when that is free or being taken.
  assign res_load = (state == S_DONE) && (!resp_valid || !resp_stall);

  // Memory port requests for the current step.
  always_comb begin
    map_req = '0;
    bk_req  = '0;
    case (state)
      S_CHECK: begin
        map_req.re    = is_access && addr_in;
        map_req.raddr = item.address;
      end
      S_SCAN: begin
        map_req.re    = !issued_all;
        map_req.raddr = ptr;
      end
      S_FILL: begin
        map_req.we           = 1'b1;
        map_req.waddr        = ptr;
        map_req.wdata.mapped = 1'b1;
        map_req.wdata.mem    = item.memory_id;
        map_req.wdata.idx    = fill_idx;
      end
      S_UNPLUG: begin
        map_req.we    = 1'b1;
        map_req.waddr = ptr;
      end
      S_LK_B: begin
        // Look up the next address while the first byte is fetched or written.
        map_req.re    = addr_lt_last;
        map_req.raddr = item.address + 16'd1;
        bk_req.re     = ok0 && !is_write;
        bk_req.raddr  = map_rdata.idx;
        bk_req.we     = ok0 && is_write;
        bk_req.waddr  = map_rdata.idx;
        bk_req.wlane  = map_rdata.mem;
        bk_req.wdata  = item.write_data[7:0];
      end
      S_LK_C: begin
        bk_req.re    = ok1 && (item.command == CMD_READ16);
        bk_req.raddr = map_rdata.idx;
        bk_req.we    = ok1 && (item.command == CMD_WRITE16);
        bk_req.waddr = map_rdata.idx;
        bk_req.wlane = map_rdata.mem;
        bk_req.wdata = item.write_data[15:8];
      end
      default: begin
      end
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      resp_valid <= 1'b0;
      for (int c = 0; c < NUM_COMPONENTS; c++) begin
        comp_start[c] <= 16'd0;
        comp_end[c]   <= 16'd0;
      end
    end else begin
      // Result register: load a finished result, or empty it once taken.
      if (res_load) begin
        resp_valid <= 1'b1;
        resp_data  <= res;
      end else if (resp_valid && !resp_stall) begin
        resp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid && !req_stall) begin
            item  <= req_data;
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          res <= '{status: (check_param ? ST_PARAM : ST_OK), read_data: 16'd0};
          if (item.command == CMD_PLUG || item.command == CMD_FORCED ||
              item.command == CMD_REMAP) begin
            if (!cid_ok || !mid_ok) begin
              state <= S_DONE;
            end else begin
              walk_s  <= (item.command == CMD_REMAP) ? comp_start[cidx] : item.range_start;
              walk_e  <= (item.command == CMD_REMAP) ? comp_end[cidx] : item.range_end;
              off_eff <= (item.command == CMD_PLUG) ? 16'd0 : item.mem_offset;
              ptr        <= item.range_start;
              rd_pend    <= 1'b0;
              issued_all <= 1'b0;
              if (item.command == CMD_PLUG && {1'b0, item.range_end} < SPACE &&
                  item.range_start <= item.range_end) begin
                state <= S_SCAN;
              end else begin
                state <= S_RCHK;
              end
            end
          end else if (item.command == CMD_UNPLUG) begin
            if (!cid_ok) begin
              state <= S_DONE;
            end else if (comp_start[cidx] <= comp_end[cidx] &&
                         {1'b0, comp_start[cidx]} < SPACE) begin
              walk_s <= comp_start[cidx];
              walk_e <= comp_end[cidx];
              ptr    <= comp_start[cidx];
              state  <= S_UNPLUG;
            end else begin
              comp_start[cidx] <= 16'd0;
              comp_end[cidx]   <= 16'd0;
              state            <= S_DONE;
            end
          end else begin
            state <= S_LK_B;
          end
        end

        // Plug: look for any address of the range that is already mapped.
        S_SCAN: begin
          if (rd_pend && map_rdata.mapped) begin
            res.status <= ST_ADDR;
            state      <= S_DONE;
          end else if (rd_pend && rd_last) begin
            state <= S_RCHK;
          end
          rd_pend <= !issued_all;
          if (!issued_all) begin
            rd_last    <= (ptr == walk_e);
            issued_all <= (ptr == walk_e);
            ptr        <= ptr + 16'd1;
          end
        end

        S_RCHK: begin
          if (range_bad) begin
            res.status <= ST_ADDR;
            state      <= S_DONE;
          end else begin
            if (item.command != CMD_REMAP) begin
              comp_start[cidx] <= walk_s;
              comp_end[cidx]   <= walk_e;
            end
            ptr      <= walk_s;
            fill_idx <= off_eff;
            state    <= S_FILL;
          end
        end

        // Map the range one address per cycle.
        S_FILL: begin
          ptr      <= ptr + 16'd1;
          fill_idx <= fill_idx + 16'd1;
          if (ptr == walk_e) begin
            state <= S_DONE;
          end
        end

        // Clear the stored range one address per cycle.
        S_UNPLUG: begin
          ptr <= ptr + 16'd1;
          if (ptr == walk_e || {1'b0, ptr} == LAST) begin
            comp_start[cidx] <= 16'd0;
            comp_end[cidx]   <= 16'd0;
            state            <= S_DONE;
          end
        end

        // First entry is back; the first byte is read or written.
        S_LK_B: begin
          ok0_r <= ok0;
          lane0 <= map_rdata.mem[LW-1:0];
          if (is_write) begin
            if (!ok0) begin
              res.status <= ST_PARAM;
              state      <= S_DONE;
            end else if (item.command == CMD_WRITE8) begin
              state <= S_DONE;
            end else begin
              state <= S_LK_C;
            end
          end else begin
            state <= S_LK_C;
          end
        end

        // Second entry and first byte are back.
        S_LK_C: begin
          ok1_r <= ok1;
          lane1 <= map_rdata.mem[LW-1:0];
          if (item.command == CMD_READ8) begin
            res.read_data <= ok0_r ? {8'h00, bk_rdata[lane0]} : {8'h00, UNMAPPED_BYTE};
            state         <= S_DONE;
          end else if (item.command == CMD_READ16) begin
            if (!ok0_r || !addr_lt_last) begin
              res.read_data <= {8'h00, UNMAPPED_BYTE};
              state         <= S_DONE;
            end else begin
              low_byte <= bk_rdata[lane0];
              state    <= S_LK_D;
            end
          end else begin
            state <= S_DONE;
          end
        end

        S_LK_D: begin
          res.read_data <= {(ok1_r ? bk_rdata[lane1] : UNMAPPED_BYTE), low_byte};
          state         <= S_DONE;
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The map is written only while a plug, forced plug, remap or unplug walks its range.
  assert property (@(posedge clk) disable iff (rst)
    map_req.we |-> (state == S_FILL || state == S_UNPLUG))
    else $error("map write outside a walk");

  // Walks stay inside the range that was checked.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL || state == S_UNPLUG) |-> (ptr >= walk_s && ptr <= walk_e))
    else $error("walk pointer left its range");

  // The backing store is written only by write commands.
  assert property (@(posedge clk) disable iff (rst)
    bk_req.we |-> (item.command == CMD_WRITE8 || item.command == CMD_WRITE16))
    else $error("backing write by a non-write request");

  // A new result appears only from the finishing step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(resp_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the finishing step");

  // No request is taken while the memories are being cleared.
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> (state == S_IDLE && req_stall))
    else $error("request work during the clearing pass");
`endif

endmodule

### sv/memory_mapped_bus_mapper_core.sv
`timescale 1ns / 1ps
// Top level of the memory-mapped bus mapper: clearing pass and memory muxing.
// Depends on mmbm_pkg, mmbm_map_table, mmbm_backing and mmbm_ctrl.
//
//   channel | signals                          | direction
//   request | req_valid, req_stall, req_data   | in  (req_stall driven here)
//   result  | resp_valid, resp_stall, resp_data | out (resp_stall driven by sink)
//
// One request at a time; each request gives one result. An access is a map lookup, then
// a byte access, each a registered memory read. A read16 stops after the first byte when
// it is unmapped or at the last address, and so does a refused write16. Plug checks each
// map entry of its range, then writes each; forced plug and remap write each entry and
// unplug clears each: one map entry per cycle; a refusal ends the command early.
// After reset a clearing pass over max(ADDRESS_SPACE, MAX_MEMORY_SIZE) addresses zeroes
// both memories, with req_stall high. A result waiting under resp_stall does not block
// acceptance of the next request.
module memory_mapped_bus_mapper_core
  import mmbm_pkg::*;
#(
  parameter int ADDRESS_SPACE   = 65536,
  parameter int NUM_COMPONENTS  = 8,
  parameter int NUM_MEMORIES    = 8,
  parameter int MAX_MEMORY_SIZE = 65536
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  req_t  req_data,
  output logic  resp_valid,
  input  logic  resp_stall,
  output resp_t resp_data
);

  localparam int CLR_N = (ADDRESS_SPACE > MAX_MEMORY_SIZE) ? ADDRESS_SPACE : MAX_MEMORY_SIZE;
  localparam int CW    = $clog2(CLR_N + 1);
  localparam logic [CW-1:0] CLR_END  = CW'(CLR_N);
  localparam logic [CW-1:0] CLR_MAP  = CW'(ADDRESS_SPACE);
  localparam logic [CW-1:0] CLR_BACK = CW'(MAX_MEMORY_SIZE);

  logic [CW-1:0]                clr_cnt;
  logic                         clearing;
  map_req_t                     ctrl_map_req;
  map_req_t                     map_req;
  map_entry_t                   map_rdata;
  bk_req_t                      ctrl_bk_req;
  bk_req_t                      bk_req;
  logic [NUM_MEMORIES-1:0][7:0] bk_rdata;

  // Clearing pass counter: one map entry and one backing row per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CW'(1);
    end
  end

  assign clearing = clr_cnt < CLR_END;

  // Memory ports go to the clearing pass first, then to the sequencer.
  always_comb begin
    map_req = ctrl_map_req;
    bk_req  = ctrl_bk_req;
    if (clearing) begin
      map_req       = '0;
      map_req.we    = clr_cnt < CLR_MAP;
      map_req.waddr = 16'(clr_cnt);
      bk_req        = '0;
      bk_req.we     = clr_cnt < CLR_BACK;
      bk_req.wall   = 1'b1;
      bk_req.waddr  = 16'(clr_cnt);
    end
  end

  mmbm_map_table #(
    .ADDRESS_SPACE(ADDRESS_SPACE)
  ) u_map (
    .clk  (clk),
    .req  (map_req),
    .rdata(map_rdata)
  );

  mmbm_backing #(
    .NUM_MEMORIES   (NUM_MEMORIES),
    .MAX_MEMORY_SIZE(MAX_MEMORY_SIZE)
  ) u_backing (
    .clk  (clk),
    .req  (bk_req),
    .rdata(bk_rdata)
  );

  mmbm_ctrl #(
    .ADDRESS_SPACE  (ADDRESS_SPACE),
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .NUM_MEMORIES   (NUM_MEMORIES),
    .MAX_MEMORY_SIZE(MAX_MEMORY_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .resp_valid(resp_valid),
    .resp_stall(resp_stall),
    .resp_data (resp_data),
    .map_req   (ctrl_map_req),
    .map_rdata (map_rdata),
    .bk_req    (ctrl_bk_req),
    .bk_rdata  (bk_rdata)
  );

endmodule
